// ===== design/fixed_partition_fit_allocator_top_macros.svh =====
// Assertion macros used by the allocator datapath.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define FPFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa check failed");

// Next-cycle implication, checked on clk outside of reset.
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa check failed");

`endif

// ===== design/fpfa_pkg.sv =====
// Package with types, constants and register codes of the partition allocator.
package fpfa_pkg;

    // Partition count and derived widths.
    localparam int NUM_PARTS     = 4;
    localparam int IDX_W         = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int SIZE_REGS     = 4;
    localparam int SIZE_W        = 16;
    localparam int OWNER_W       = 8;
    localparam int PART_INDEX_W  = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 3'd0;
    localparam int                   REG_SIZE_BASE  = 1;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Capacities after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET [SIZE_REGS] = '{
        16'd20, 16'd10, 16'd30, 16'd40
    };

    // Placement policy; the unused code behaves as first fit.
    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_PICK = 1'b1
    } state_t;

    // Input beat.
    typedef struct packed {
        logic               req_type;
        logic [SIZE_W-1:0]  req_size;
        logic [OWNER_W-1:0] owner_id;
    } req_t;

    // Output beat.
    typedef struct packed {
        logic                    granted;
        logic [PART_INDEX_W-1:0] part_index;
        logic [SIZE_W-1:0]       part_capacity;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } status_t;

endpackage

// ===== design/fpfa_ctrl.sv =====
// Controller state machine of the partition allocator.
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    // The output register can take a result when empty or when its beat leaves now.
    assign out_free = !status.out_full || !out_stall;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_PICK:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/fpfa_dp.sv =====
// Datapath of the partition allocator: configuration, partition state, selection, output.
`include "fixed_partition_fit_allocator_top_macros.svh"

module fpfa_dp
    import fpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 in_data,
    output rsp_t                 out_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                 cmd,
    output status_t              status
);

    policy_t            policy_reg;
    logic [SIZE_W-1:0]  part_cap [NUM_PARTS];
    logic [NUM_PARTS-1:0] busy_reg;
    logic [OWNER_W-1:0] owner_reg [NUM_PARTS];
    req_t               req_reg;
    rsp_t               rsp_reg;
    logic               out_valid_reg;

    logic [NUM_PARTS-1:0] fits;
    logic               found;
    logic [IDX_W-1:0]   pick_idx;
    logic [SIZE_W-1:0]  pick_cap;
    logic               is_clear;

    // Fit policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
        end
        else if (cfg_we && (cfg_index == REG_FIT_POLICY))
        begin
            policy_reg <= policy_t'(cfg_data[1:0]);
        end
    end

    // Capacity registers; partitions past the size registers have capacity zero.
    for (genvar p = 0; p < NUM_PARTS; p++)
    begin : g_cap
        if (p < SIZE_REGS)
        begin : g_reg
            logic [SIZE_W-1:0] size_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    size_reg <= SIZE_RESET[p];
                end
                else if (cfg_we && (cfg_index == CFG_IDX_W'(REG_SIZE_BASE + p)))
                begin
                    size_reg <= cfg_data[SIZE_W-1:0];
                end
            end
            assign part_cap[p] = size_reg;
        end
        else
        begin : g_zero
            assign part_cap[p] = '0;
        end
    end

    // Request register, loaded when a beat is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
    end

    assign is_clear = (req_reg.req_type == REQ_CLEAR);

    // Fit test on every partition in parallel.
    always_comb
    begin
        for (int i = 0; i < NUM_PARTS; i++)
        begin
            fits[i] = !busy_reg[i] && (part_cap[i] >= req_reg.req_size);
        end
    end

    // Selection by policy; a later partition wins only on a strict improvement.
    always_comb
    begin
        found    = 1'b0;
        pick_idx = '0;
        pick_cap = '0;
        for (int i = 0; i < NUM_PARTS; i++)
        begin
            if (fits[i])
            begin
                if (!found)
                begin
                    found    = 1'b1;
                    pick_idx = IDX_W'(i);
                    pick_cap = part_cap[i];
                end
                else
                begin
                    case (policy_reg)
                        POL_BEST:
                        begin
                            if (part_cap[i] < pick_cap)
                            begin
                                pick_idx = IDX_W'(i);
                                pick_cap = part_cap[i];
                            end
                        end
                        POL_WORST:
                        begin
                            if (part_cap[i] > pick_cap)
                            begin
                                pick_idx = IDX_W'(i);
                                pick_cap = part_cap[i];
                            end
                        end
                        default:
                        begin
                            pick_idx = pick_idx;
                        end
                    endcase
                end
            end
        end
    end

    // Busy bits: cleared by a clear request, set on a grant.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (is_clear)
            begin
                busy_reg <= '0;
            end
            else if (found)
            begin
                busy_reg[pick_idx] <= 1'b1;
            end
        end
    end

    // Owner store, written on a grant.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !is_clear && found)
        begin
            owner_reg[pick_idx] <= req_reg.owner_id;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (!is_clear && found)
            begin
                rsp_reg.granted       <= 1'b1;
                rsp_reg.part_index    <= PART_INDEX_W'(pick_idx);
                rsp_reg.part_capacity <= pick_cap;
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_data        = rsp_reg;
    assign out_valid       = out_valid_reg;
    assign status.out_full = out_valid_reg;

    // A grant marks the chosen partition busy and records its owner.
    `FPFA_ASSERT_NEXT(a_grant_busy, cmd.commit && !is_clear && found,
        busy_reg[$past(pick_idx)])
    `FPFA_ASSERT_NEXT(a_grant_owner, cmd.commit && !is_clear && found,
        owner_reg[$past(pick_idx)] == $past(req_reg.owner_id))
    // A clear request frees every partition.
    `FPFA_ASSERT_NEXT(a_clear_all, cmd.commit && is_clear, busy_reg == '0)
    // A committed result is always presented in the next cycle.
    `FPFA_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid)

endmodule

// ===== design/fixed_partition_fit_allocator_top.sv =====
// Top level of the fixed-partition allocator: controller and datapath.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall   req_t   (req_type, req_size, owner_id)
//   out      output     out_valid / out_stall rsp_t  (granted, part_index, part_capacity)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Each request passes two steps: the idle state captures the beat, then the pick state
// compares all partitions, commits the result and busy bits and then returns to idle.
// The commit cycle waits while the output register holds a beat that is stalled.
// The output register lets a new request be captured while a result still waits.
// Reset frees every partition and restores the policy and capacity registers.
module fixed_partition_fit_allocator_top
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsp_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Sequencing.
    fpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Partition state and selection.
    fpfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
